// File: rtl/sti_pkg.sv
// shared constants and types for the segment / triangle hit test
// no dependencies; compiled first
package sti_pkg;

	// default coordinate width of one signed fixed-point coordinate
	localparam int COORD_BITS_DEF = 16;

	// determinant threshold register
	localparam int          EPS_W   = 20;
	localparam logic [19:0] EPS_RST = 20'd168;

	// number of pipeline stages, output register included
	localparam int STG_N = 7;

	// enables for the two stages of a cross product unit
	typedef struct packed {
		logic mul_en;
		logic sub_en;
	} xprod_ctl_t;

endpackage

// File: rtl/sti_if.sv
// valid / ready channel interfaces for the item and result streams
// depends on sti_pkg
interface sti_in_if import sti_pkg::*; #(
	parameter int PT_W = 3 * COORD_BITS_DEF
) ();
	logic            valid;
	logic            ready;
	logic [PT_W-1:0] seg_start;
	logic [PT_W-1:0] seg_end;
	logic [PT_W-1:0] vert_a;
	logic [PT_W-1:0] vert_b;
	logic [PT_W-1:0] vert_c;

	modport source (output valid, seg_start, seg_end, vert_a, vert_b, vert_c, input ready);
	modport sink (input valid, seg_start, seg_end, vert_a, vert_b, vert_c, output ready);
endinterface

interface sti_out_if ();
	logic valid;
	logic ready;
	logic hit;

	modport source (output valid, hit, input ready);
	modport sink (input valid, hit, output ready);
endinterface

// File: rtl/sti_cross.sv
// two-stage cross product r = a x b: registered products, then registered differences
// depends on sti_pkg
module sti_cross import sti_pkg::*; #(
	parameter int DW = COORD_BITS_DEF + 1
) (
	input  logic                     clk,
	input  xprod_ctl_t               ctl,
	input  logic signed [DW-1:0]     a [3],
	input  logic signed [DW-1:0]     b [3],
	output logic signed [2*DW:0]     r [3]
);

	localparam int PW = 2 * DW;
	localparam int XW = 2 * DW + 1;

	logic signed [PW-1:0] pl_s2 [3];
	logic signed [PW-1:0] pr_s2 [3];
	logic signed [XW-1:0] r_s3  [3];

	// product stage: left and right terms of each component
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			pl_s2[0] <= PW'(a[1]) * PW'(b[2]);
			pr_s2[0] <= PW'(a[2]) * PW'(b[1]);
			pl_s2[1] <= PW'(a[2]) * PW'(b[0]);
			pr_s2[1] <= PW'(a[0]) * PW'(b[2]);
			pl_s2[2] <= PW'(a[0]) * PW'(b[1]);
			pr_s2[2] <= PW'(a[1]) * PW'(b[0]);
		end
	end

	// difference stage
	always_ff @(posedge clk) begin
		if (ctl.sub_en) begin
			for (int k = 0; k < 3; k++) begin
				r_s3[k] <= XW'(pl_s2[k]) - XW'(pr_s2[k]);
			end
		end
	end

	assign r = r_s3;

endmodule

// File: rtl/segment_triangle_intersect_top.sv
// segment / triangle hit test, division free, exact integer arithmetic
// result path: one register per stage, from stage 1 through the stage 7 output register
// throughput: one item per cycle while result.ready is high; each stage advances when its successor is free
// reset (arst_n low): all stage valid bits clear, det_epsilon returns to 168
// depends on sti_pkg, sti_if, sti_cross
module segment_triangle_intersect_top import sti_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	sti_in_if.sink           seg_tri,
	sti_out_if.source        result,
	input  logic             det_epsilon_we,
	input  logic [EPS_W-1:0] det_epsilon_wdata
);

	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;          // coordinate difference
	localparam int XW = 2 * DW + 1;      // cross product component
	localparam int MW = DW + XW;         // dot product term
	localparam int SW = MW + 2;          // dot product sum

	// stage control
	logic [STG_N:1]   vld_q;
	logic [STG_N+1:1] adv;
	logic [EPS_W-1:0] eps_q;

	// stage 1
	logic signed [DW-1:0] dir_s1 [3];
	logic signed [DW-1:0] e1_s1  [3];
	logic signed [DW-1:0] e2_s1  [3];
	logic signed [DW-1:0] tv_s1  [3];
	// stages 2 and 3 operand carry
	logic signed [DW-1:0] dir_s2 [3];
	logic signed [DW-1:0] e1_s2  [3];
	logic signed [DW-1:0] e2_s2  [3];
	logic signed [DW-1:0] tv_s2  [3];
	logic signed [DW-1:0] dir_s3 [3];
	logic signed [DW-1:0] e1_s3  [3];
	logic signed [DW-1:0] e2_s3  [3];
	logic signed [DW-1:0] tv_s3  [3];
	logic signed [XW-1:0] pv_s3  [3];
	logic signed [XW-1:0] qv_s3  [3];
	xprod_ctl_t           xctl;
	// stage 4 dot product terms
	logic signed [MW-1:0] tdet_s4 [3];
	logic signed [MW-1:0] tu_s4   [3];
	logic signed [MW-1:0] tv4_s4  [3];
	logic signed [MW-1:0] tt_s4   [3];
	// stage 5 sums, stage 6 sign adjusted
	logic signed [SW-1:0] det_s5, u_s5, v_s5, t_s5;
	logic signed [SW-1:0] det_s6, u_s6, v_s6, t_s6;
	logic                 hit_s7;
	// final compare
	logic signed [SW:0]   uv_sum;
	logic signed [SW-1:0] eps_ext;
	logic                 hit_d;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RST;
		end else if (det_epsilon_we) begin
			eps_q <= det_epsilon_wdata;
		end
	end

	// a stage may load when it is empty or its content moves on
	always_comb begin
		adv[STG_N+1] = result.ready;
		for (int k = STG_N; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) vld_q[1] <= seg_tri.valid;
			for (int k = 2; k <= STG_N; k++) begin
				if (adv[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign seg_tri.ready = adv[1];

	// stage 1: edge and direction vectors, and tvec = seg_start - vert_a
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			for (int k = 0; k < 3; k++) begin
				dir_s1[k] <= DW'($signed(seg_tri.seg_end[k*CB +: CB]))
				           - DW'($signed(seg_tri.seg_start[k*CB +: CB]));
				e1_s1[k]  <= DW'($signed(seg_tri.vert_b[k*CB +: CB]))
				           - DW'($signed(seg_tri.vert_a[k*CB +: CB]));
				e2_s1[k]  <= DW'($signed(seg_tri.vert_c[k*CB +: CB]))
				           - DW'($signed(seg_tri.vert_a[k*CB +: CB]));
				tv_s1[k]  <= DW'($signed(seg_tri.seg_start[k*CB +: CB]))
				           - DW'($signed(seg_tri.vert_a[k*CB +: CB]));
			end
		end
	end

	// stages 2 and 3: pvec = dir x edge2, qvec = tvec x edge1
	assign xctl.mul_en = adv[2];
	assign xctl.sub_en = adv[3];

	sti_cross #(.DW(DW)) u_pvec (
		.clk (clk),
		.ctl (xctl),
		.a   (dir_s1),
		.b   (e2_s1),
		.r   (pv_s3)
	);

	sti_cross #(.DW(DW)) u_qvec (
		.clk (clk),
		.ctl (xctl),
		.a   (tv_s1),
		.b   (e1_s1),
		.r   (qv_s3)
	);

	// operand carry alongside the cross products
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			dir_s2 <= dir_s1;
			e1_s2  <= e1_s1;
			e2_s2  <= e2_s1;
			tv_s2  <= tv_s1;
		end
		if (adv[3]) begin
			dir_s3 <= dir_s2;
			e1_s3  <= e1_s2;
			e2_s3  <= e2_s2;
			tv_s3  <= tv_s2;
		end
	end

	// stage 4: dot product terms
	always_ff @(posedge clk) begin
		if (adv[4]) begin
			for (int k = 0; k < 3; k++) begin
				tdet_s4[k] <= MW'(e1_s3[k])  * MW'(pv_s3[k]);
				tu_s4[k]   <= MW'(tv_s3[k])  * MW'(pv_s3[k]);
				tv4_s4[k]  <= MW'(dir_s3[k]) * MW'(qv_s3[k]);
				tt_s4[k]   <= MW'(e2_s3[k])  * MW'(qv_s3[k]);
			end
		end
	end

	// stage 5: det and the three numerators
	always_ff @(posedge clk) begin
		if (adv[5]) begin
			det_s5 <= SW'(tdet_s4[0]) + SW'(tdet_s4[1]) + SW'(tdet_s4[2]);
			u_s5   <= SW'(tu_s4[0]) + SW'(tu_s4[1]) + SW'(tu_s4[2]);
			v_s5   <= SW'(tv4_s4[0]) + SW'(tv4_s4[1]) + SW'(tv4_s4[2]);
			t_s5   <= SW'(tt_s4[0]) + SW'(tt_s4[1]) + SW'(tt_s4[2]);
		end
	end

	// stage 6: flip signs so that det is non-negative
	always_ff @(posedge clk) begin
		if (adv[6]) begin
			if (det_s5[SW-1]) begin
				det_s6 <= -det_s5;
				u_s6   <= -u_s5;
				v_s6   <= -v_s5;
				t_s6   <= -t_s5;
			end else begin
				det_s6 <= det_s5;
				u_s6   <= u_s5;
				v_s6   <= v_s5;
				t_s6   <= t_s5;
			end
		end
	end

	// inclusive bound checks
	always_comb begin
		eps_ext = SW'(eps_q);
		uv_sum  = (SW+1)'(u_s6) + (SW+1)'(v_s6);
		hit_d   = (det_s6 >= eps_ext)
		       && !u_s6[SW-1] && (u_s6 <= det_s6)
		       && !v_s6[SW-1] && (uv_sum <= (SW+1)'(det_s6))
		       && !t_s6[SW-1] && (t_s6 <= det_s6);
	end

	// stage 7: output register
	always_ff @(posedge clk) begin
		if (adv[7]) begin
			hit_s7 <= hit_d;
		end
	end

	assign result.valid = vld_q[STG_N];
	assign result.hit   = hit_s7;

endmodule

// File: rtl/sti_checker.sv
// port-level checks on the hit test pipeline, bound to the top level
// depends on sti_pkg and segment_triangle_intersect_top
module sti_checker import sti_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_hit
);

	localparam int CW = $clog2(STG_N + 2);

	logic [CW-1:0] inflight_q;
	logic          in_xfer;
	logic          out_xfer;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			inflight_q <= inflight_q + CW'(1);
		end else if (out_xfer && !in_xfer) begin
			inflight_q <= inflight_q - CW'(1);
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_hit))
		else $error("result changed while stalled");

	// an empty or draining output never blocks the input
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input blocked while output free");

	// no result without an item behind it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result without accepted item");

	// never more items inside than stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CW'(STG_N))
		else $error("pipeline holds more items than stages");

endmodule

bind segment_triangle_intersect_top sti_checker u_sti_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (seg_tri.valid),
	.in_ready  (seg_tri.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_hit   (result.hit)
);
